// ===== rtl/ecal_pkg.sv =====
// ----------------------------------------------------------------------------
// ecal_pkg: shared types for the epoch seconds to calendar unit
// Micro-op and jump-condition codes, control word, status flags, month table.
// ----------------------------------------------------------------------------
package ecal_pkg;

   localparam int StepW     = 4;
   localparam int StepCount = 2 ** StepW;

   localparam int DaysW = 16;
   localparam int YearW = 11;

   localparam logic [31:0] Recip60 = 32'h8888_8889;
   localparam logic [31:0] Recip24 = 32'hAAAA_AAAB;
   localparam logic [31:0] SecPerMin = 32'd60;
   localparam logic [31:0] HourPerDay = 32'd24;

   localparam logic [YearW-1:0] EpochYear = 11'd1970;
   localparam logic [YearW-1:0] BaseYear  = 11'd2000;
   localparam logic [DaysW-1:0] DaysLeap  = 16'd366;
   localparam logic [DaysW-1:0] DaysNorm  = 16'd365;

   typedef logic [StepW-1:0] step_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL60,
      OP_MUL24,
      OP_SEC,
      OP_MIN,
      OP_HOUR,
      OP_YEAR,
      OP_MONTH,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_YEAR_MORE,
      COND_MONTH_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctl_type;

   typedef struct packed {
      logic no_req;
      logic year_more;
      logic month_more;
      logic out_busy;
   } status_type;

   function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
      logic [4:0] len;
      case (mon)
         4'd1:    len = leap ? 5'd29 : 5'd28;
         4'd3:    len = 5'd30;
         4'd5:    len = 5'd30;
         4'd8:    len = 5'd30;
         4'd10:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// ===== rtl/ecal_seq.sv =====
// ----------------------------------------------------------------------------
// ecal_seq: microcode sequencer
// Step counter over a read-only program; one control word per step,
// conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module ecal_seq
   import ecal_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output ctl_type    ctl,
   output logic       idle
);

   localparam step_type StepIdle  = 4'd0;
   localparam step_type StepYear  = 4'd7;
   localparam step_type StepMonth = 4'd8;
   localparam step_type StepEmit  = 4'd9;

   localparam ctl_type Program [StepCount] = '{
      '{OP_LOAD,  COND_NO_REQ,     StepIdle},
      '{OP_MUL60, COND_NEXT,       StepIdle},
      '{OP_SEC,   COND_NEXT,       StepIdle},
      '{OP_MUL60, COND_NEXT,       StepIdle},
      '{OP_MIN,   COND_NEXT,       StepIdle},
      '{OP_MUL24, COND_NEXT,       StepIdle},
      '{OP_HOUR,  COND_NEXT,       StepIdle},
      '{OP_YEAR,  COND_YEAR_MORE,  StepYear},
      '{OP_MONTH, COND_MONTH_MORE, StepMonth},
      '{OP_EMIT,  COND_OUT_BUSY,   StepEmit},
      '{OP_NONE,  COND_ALWAYS,     StepIdle},
      '{OP_NONE,  COND_ALWAYS,     StepIdle},
      '{OP_NONE,  COND_ALWAYS,     StepIdle},
      '{OP_NONE,  COND_ALWAYS,     StepIdle},
      '{OP_NONE,  COND_ALWAYS,     StepIdle},
      '{OP_NONE,  COND_ALWAYS,     StepIdle}
   };

   step_type pc_ff, pc_in;
   logic     jump;

   assign ctl  = Program[pc_ff];
   assign idle = (pc_ff == StepIdle);

   always_comb begin
      case (ctl.cond)
         COND_NEXT:       jump = 1'b0;
         COND_ALWAYS:     jump = 1'b1;
         COND_NO_REQ:     jump = status.no_req;
         COND_YEAR_MORE:  jump = status.year_more;
         COND_MONTH_MORE: jump = status.month_more;
         COND_OUT_BUSY:   jump = status.out_busy;
         default:         jump = 1'b1;
      endcase
      pc_in = jump ? ctl.target : pc_ff + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= StepIdle;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== rtl/ecal_dpath.sv =====
// ----------------------------------------------------------------------------
// ecal_dpath: conversion datapath
// Reciprocal multiplier for the time-of-day split, year and month
// subtractors with leap tracking, and the result register.
// ----------------------------------------------------------------------------
module ecal_dpath
   import ecal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  ctl_type     ctl,
   input  logic        req_valid,
   input  logic [31:0] req_epoch_seconds,
   output status_type  status,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_second,
   output logic [5:0]  rsp_minute,
   output logic [4:0]  rsp_hour,
   output logic [4:0]  rsp_day_of_month,
   output logic [3:0]  rsp_month,
   output logic [7:0]  rsp_year_two_digit
);

   logic [31:0]      t_ff;
   logic [63:0]      prod_ff;
   logic [5:0]       sec_ff, min_ff;
   logic [4:0]       hour_ff;
   logic [DaysW-1:0] days_ff;
   logic [YearW-1:0] year_ff;
   logic [1:0]       ymod4_ff;
   logic [6:0]       ymod100_ff;
   logic [8:0]       ymod400_ff;
   logic [3:0]       mon_ff;
   logic             rsp_valid_ff;
   logic [5:0]       rsp_second_ff;
   logic [5:0]       rsp_minute_ff;
   logic [4:0]       rsp_hour_ff;
   logic [4:0]       rsp_day_of_month_ff;
   logic [3:0]       rsp_month_ff;
   logic [7:0]       rsp_year_two_digit_ff;

   logic [31:0]      q60, q24, r60, r24;
   logic             leap;
   logic [DaysW-1:0] year_len, mon_len;
   logic [YearW-1:0] year_off;
   logic [DaysW-1:0] day_next;

   assign q60 = {5'd0, prod_ff[63:37]};
   assign q24 = {4'd0, prod_ff[63:36]};
   assign r60 = t_ff - q60 * SecPerMin;
   assign r24 = t_ff - q24 * HourPerDay;

   assign leap     = ((ymod4_ff == 2'd0) && (ymod100_ff != 7'd0)) || (ymod400_ff == 9'd0);
   assign year_len = leap ? DaysLeap : DaysNorm;
   assign mon_len  = {11'd0, month_len(leap, mon_ff)};
   assign year_off = year_ff - BaseYear;
   assign day_next = days_ff + 16'd1;

   assign status.no_req     = !req_valid;
   assign status.year_more  = (days_ff >= year_len);
   assign status.month_more = (days_ff >= mon_len);
   assign status.out_busy   = rsp_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      case (ctl.op)
         OP_LOAD: begin
            if (req_valid) begin
               t_ff       <= req_epoch_seconds;
               year_ff    <= EpochYear;
               ymod4_ff   <= 2'd2;
               ymod100_ff <= 7'd70;
               ymod400_ff <= 9'd370;
               mon_ff     <= 4'd0;
            end
         end
         OP_MUL60: prod_ff <= t_ff * Recip60;
         OP_MUL24: prod_ff <= t_ff * Recip24;
         OP_SEC: begin
            sec_ff <= r60[5:0];
            t_ff   <= q60;
         end
         OP_MIN: begin
            min_ff <= r60[5:0];
            t_ff   <= q60;
         end
         OP_HOUR: begin
            hour_ff <= r24[4:0];
            days_ff <= q24[DaysW-1:0];
         end
         OP_YEAR: begin
            if (status.year_more) begin
               days_ff    <= days_ff - year_len;
               year_ff    <= year_ff + 11'd1;
               ymod4_ff   <= ymod4_ff + 2'd1;
               ymod100_ff <= (ymod100_ff == 7'd99) ? 7'd0 : ymod100_ff + 7'd1;
               ymod400_ff <= (ymod400_ff == 9'd399) ? 9'd0 : ymod400_ff + 9'd1;
            end
         end
         OP_MONTH: begin
            if (status.month_more) begin
               days_ff <= days_ff - mon_len;
               mon_ff  <= mon_ff + 4'd1;
            end
         end
         OP_EMIT: begin
            if (!status.out_busy) begin
               rsp_second_ff         <= sec_ff;
               rsp_minute_ff         <= min_ff;
               rsp_hour_ff           <= hour_ff;
               rsp_day_of_month_ff   <= day_next[4:0];
               rsp_month_ff          <= mon_ff + 4'd1;
               rsp_year_two_digit_ff <= year_off[7:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((ctl.op == OP_EMIT) && !status.out_busy) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_second         = rsp_second_ff;
   assign rsp_minute         = rsp_minute_ff;
   assign rsp_hour           = rsp_hour_ff;
   assign rsp_day_of_month   = rsp_day_of_month_ff;
   assign rsp_month          = rsp_month_ff;
   assign rsp_year_two_digit = rsp_year_two_digit_ff;

endmodule

// ===== rtl/epoch_seconds_to_calendar_unit.sv =====
// Steps: load, split off seconds, minutes and hours by reciprocal multiply,
// then subtract one year per cycle from 1970 (up to 136 whole years) and one
// month per cycle (up to 11), then emit. Throughput: one conversion at a time;
// the next input is taken only once the step counter is back at idle.
// A waiting result does not hold off the next input until it must be replaced.
// Reset clears the step counter and the result valid; no clearing pass.
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit: epoch seconds to calendar date and time
// Microcoded sequencer driving a multiply/subtract datapath that splits a
// 32-bit seconds count into time of day, year, month and day of month.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit
   import ecal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_second,
   output logic [5:0]  rsp_minute,
   output logic [4:0]  rsp_hour,
   output logic [4:0]  rsp_day_of_month,
   output logic [3:0]  rsp_month,
   output logic [7:0]  rsp_year_two_digit
);

   ctl_type    ctl;
   status_type status;
   logic       idle;

   assign req_stall = !idle;

   ecal_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl),
      .idle   (idle)
   );

   ecal_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .req_valid          (req_valid),
      .req_epoch_seconds  (req_epoch_seconds),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_second         (rsp_second),
      .rsp_minute         (rsp_minute),
      .rsp_hour           (rsp_hour),
      .rsp_day_of_month   (rsp_day_of_month),
      .rsp_month          (rsp_month),
      .rsp_year_two_digit (rsp_year_two_digit)
   );

endmodule

// ===== bench/epoch_seconds_to_calendar_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit_test: self-checking bench for the calendar unit
// Converts a directed set of epoch counts (field extremes, pre-2000 wrap, leap
// and century years, month and year edges, largest count) and then random
// counts. Random idle and stall on both channels. Each result transfer is
// checked field by field against an in-order queue of predicted calendars.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit_test;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [4:0] day_of_month;
      logic [3:0] month;
      logic [7:0] year_two_digit;
   } calendar_type;

   localparam int RandomItems   = 1450;
   localparam int MaxIdle       = 16;
   localparam int WatchdogLimit = 4000;
   localparam int DrainCycles   = 200;
   localparam int SecPerDay     = 86400;
   localparam int LastFullDay   = 49709;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic [31:0] req_epoch_seconds = 32'd0;
   logic        rsp_stall         = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [5:0]  rsp_second;
   logic [5:0]  rsp_minute;
   logic [4:0]  rsp_hour;
   logic [4:0]  rsp_day_of_month;
   logic [3:0]  rsp_month;
   logic [7:0]  rsp_year_two_digit;

   logic [31:0]  epoch_backlog[$];
   calendar_type calendar_due[$];
   calendar_type due;
   int           failures     = 0;
   int           send_gap     = 0;
   int           hold_left    = 0;
   bit           send_burst   = 1'b0;
   bit           hold_burst   = 1'b0;
   int           quiet_cycles = 0;

   int          item;
   int          pick;
   longint      day;
   longint      tod;
   int unsigned year;
   int unsigned mon;
   int unsigned y;
   int unsigned m;

   epoch_seconds_to_calendar_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_epoch_seconds  (req_epoch_seconds),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_second         (rsp_second),
      .rsp_minute         (rsp_minute),
      .rsp_hour           (rsp_hour),
      .rsp_day_of_month   (rsp_day_of_month),
      .rsp_month          (rsp_month),
      .rsp_year_two_digit (rsp_year_two_digit)
   );

   function automatic bit is_leap_year(input int unsigned yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
   endfunction

   // mo counts from 0 (January)
   function automatic int unsigned days_in_month(input int unsigned yr, input int unsigned mo);
      if (mo == 1)
         return is_leap_year(yr) ? 29 : 28;
      if (mo == 3 || mo == 5 || mo == 8 || mo == 10)
         return 30;
      return 31;
   endfunction

   function automatic calendar_type epoch_to_calendar(input logic [31:0] epoch);
      calendar_type cal;
      int unsigned  t;
      int unsigned  days;
      int unsigned  yr;
      int unsigned  mo;
      int unsigned  span;
      t                = epoch;
      cal.second       = 6'(t % 60);
      t                = t / 60;
      cal.minute       = 6'(t % 60);
      t                = t / 60;
      cal.hour         = 5'(t % 24);
      days             = t / 24;
      yr               = 1970;
      span             = is_leap_year(yr) ? 366 : 365;
      while (days >= span) begin
         days -= span;
         yr++;
         span = is_leap_year(yr) ? 366 : 365;
      end
      mo = 0;
      while (mo < 12 && days >= days_in_month(yr, mo)) begin
         days -= days_in_month(yr, mo);
         mo++;
      end
      cal.day_of_month   = 5'(days + 1);
      cal.month          = 4'(mo + 1);
      cal.year_two_digit = 8'(yr - 2000);
      return cal;
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      // edges of each field, pre-2000 wrap, leap days, century non-leap, largest count
      epoch_backlog = '{
         32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
         32'd2678399, 32'd2678400, 32'd68169600, 32'd94607999, 32'd94608000,
         32'd946684799, 32'd946684800, 32'd951782400, 32'd951868800,
         32'd978307199, 32'd978307200, 32'd4107456000, 32'd4107542399,
         32'd4107542400, 32'd4294967294, 32'hFFFF_FFFF
      };
      for (item = 0; item < RandomItems; item++) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            epoch_backlog.push_back($urandom);
         end else if (pick < 8) begin
            day = $urandom_range(0, LastFullDay);
            case ($urandom_range(0, 2))
               0: tod = 0;
               1: tod = SecPerDay - 1;
               default: tod = $urandom_range(0, SecPerDay - 1);
            endcase
            epoch_backlog.push_back(32'(day * SecPerDay + tod));
         end else begin
            // one second around a month start
            year = $urandom_range(1970, 2105);
            mon  = $urandom_range(0, 11);
            day  = 0;
            for (y = 1970; y < year; y++)
               day += is_leap_year(y) ? 366 : 365;
            for (m = 0; m < mon; m++)
               day += days_in_month(year, m);
            epoch_backlog.push_back(32'(day * SecPerDay + $urandom_range(0, 2) - 1));
         end
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (epoch_backlog.size() != 0 || req_valid || calendar_due.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (failures == 0 && calendar_due.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = $urandom_range(0, MaxIdle);
      end else begin
         if (req_valid && !req_stall) begin
            calendar_due.push_back(epoch_to_calendar(req_epoch_seconds));
            if ($urandom_range(0, 39) == 0)
               send_burst = !send_burst;
            send_gap = send_burst ? 0 : $urandom_range(0, MaxIdle);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap == 0 && epoch_backlog.size() != 0) begin
               req_valid         <= 1'b1;
               req_epoch_seconds <= epoch_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
               if (send_gap > 0)
                  send_gap--;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = $urandom_range(0, MaxIdle);
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (calendar_due.size() == 0) begin
               $error("result transfer with no expected calendar waiting");
               failures++;
            end else begin
               due = calendar_due.pop_front();
               check_field("second", due.second, rsp_second);
               check_field("minute", due.minute, rsp_minute);
               check_field("hour", due.hour, rsp_hour);
               check_field("day_of_month", due.day_of_month, rsp_day_of_month);
               check_field("month", due.month, rsp_month);
               check_field("year_two_digit", due.year_two_digit, rsp_year_two_digit);
            end
            if ($urandom_range(0, 39) == 0)
               hold_burst = !hold_burst;
            hold_left = hold_burst ? 0 : $urandom_range(0, MaxIdle);
         end else if (rsp_valid && hold_left > 0) begin
            hold_left--;
         end
         rsp_stall <= (hold_left != 0);
      end
   end

   // watchdog: no transfer on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ===== filelist.f =====
rtl/ecal_pkg.sv
rtl/ecal_seq.sv
rtl/ecal_dpath.sv
rtl/epoch_seconds_to_calendar_unit.sv
bench/epoch_seconds_to_calendar_unit_test.sv
